// ===== hdl/ellipse_in_rectangle_rasterizer_core_defines.svh =====
// assertion macros for the ellipse rasterizer
// used by modules that need clk and rst_n in scope
`ifndef ELLIPSE_IN_RECTANGLE_RASTERIZER_CORE_DEFINES_SVH
`define ELLIPSE_IN_RECTANGLE_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication
`define EIRR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EIRR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/eirr_pkg.sv =====
// shared types and constants of the ellipse rasterizer
// no dependencies
package eirr_pkg;

    localparam int ROWS  = 256;
    localparam int ROW_W = $clog2(ROWS);
    localparam int CRD_W = 10;
    localparam int ERR_W = 40;
    localparam int INC_W = 24;
    localparam int MUL_W = 18;
    localparam int SQ_W  = 17;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic signed [CRD_W-1:0] coord_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_AA, ST_MUL_BB, ST_MUL_DX, ST_INIT,
        ST_STEP_Y, ST_STEP_Y2, ST_STEP_X, ST_STEP_X2, ST_TAIL,
        ST_PLOT, ST_UPD, ST_FEND, ST_SEEK, ST_LOAD,
        ST_SCAN_RD, ST_SCAN_CMP, ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WALK, PH_TAIL, PH_SCAN, PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic       valid;
        logic       last;
        logic       done;
    } result_t;

endpackage

// ===== hdl/eirr_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module eirr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/ellipse_in_rectangle_rasterizer_core.sv =====
// Ellipse-in-rectangle rasterizer. A start transfer (tuser 0) gives two opposite
// corners of a box and a fill flag; the block works out the error terms with one
// shared 18x18 multiplier in states MUL_AA, MUL_BB and MUL_DX and returns one
// acknowledge. Each advance transfer (tuser 1) runs one step. Outline mode: a
// step returns four pixels, each sent when the output is free. Fill mode: walk
// steps record a per-row min/max x in a 256x16 ram (a plain write on a new row,
// a read-modify-write on a recorded row) and return one acknowledge; once the
// walk is over the interior is returned one pixel per advance in ascending y.
// Finding the next recorded row searches one row per cycle. The block takes no
// new input until the last result of the current item is in the output
// register. done_res marks the final result of the ellipse and every later ack.
// Depends on eirr_pkg, eirr_ram and the defines header.
`include "ellipse_in_rectangle_rasterizer_core_defines.svh"

module ellipse_in_rectangle_rasterizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // corner_ax, corner_ay, corner_bx, corner_by, fill, zeros
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // point_x, point_y, done_res, zeros
    output logic        m_tuser,   // point_valid
    output logic        m_tlast    // last
);

    localparam int RW = eirr_pkg::ROW_W;

    eirr_pkg::ctrl_state_t state_reg, state_next;
    eirr_pkg::phase_t      phase_reg, phase_next;

    eirr_pkg::coord_t left_reg, left_next, right_reg, right_next;
    eirr_pkg::coord_t upper_reg, upper_next, lower_reg, lower_next;
    eirr_pkg::coord_t xa_reg, xa_next, xb_reg, xb_next;
    eirr_pkg::coord_t pu_reg, pu_next, pl_reg, pl_next;
    logic [7:0] hspan_reg, hspan_next, a_reg, a_next, b_reg, b_next;
    logic [eirr_pkg::SQ_W-1:0] aa_reg, aa_next, bb_reg, bb_next;
    eirr_pkg::err_t dx_reg, dx_next, dy_reg, dy_next, err_reg, err_next;
    eirr_pkg::err_t e2_reg, e2_next;
    logic [eirr_pkg::INC_W-1:0] xi_reg, xi_next, yi_reg, yi_next;
    logic fill_reg, fill_next, cy_reg, cy_next, cx_reg, cx_next;
    logic fin_reg, fin_next, tailn_reg, tailn_next, tailpts_reg, tailpts_next;
    logic [1:0] k_reg, k_next;
    logic [eirr_pkg::ROWS-1:0] seen_reg, seen_next;
    logic [RW:0] sr_reg, sr_next;
    logic [7:0] scan_row_reg, scan_row_next, scan_x_reg, scan_x_next;
    logic [7:0] pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic pend_valid_reg, pend_valid_next, pend_done_reg, pend_done_next;
    logic out_valid_reg, out_valid_next;
    eirr_pkg::result_t out_reg, out_next;

    // shared multiplier
    logic signed [eirr_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*eirr_pkg::MUL_W-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // row min/max table: [7:0] min, [15:8] max
    logic          ram_we;
    logic [RW-1:0] ram_addr;
    logic [15:0]   ram_wdata, ram_rdata;

    eirr_ram #(.WIDTH(16), .DEPTH(eirr_pkg::ROWS)) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // input fields
    logic [7:0] in_ax, in_ay, in_bx, in_by;
    logic       in_fill, in_accept, out_free;
    assign in_ax   = s_tdata[7:0];
    assign in_ay   = s_tdata[15:8];
    assign in_bx   = s_tdata[23:16];
    assign in_by   = s_tdata[31:24];
    assign in_fill = s_tdata[32];

    assign s_tready  = (state_reg == eirr_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.done, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.valid;
    assign m_tlast  = out_reg.last;

    // current point of a walk or tail step
    eirr_pkg::coord_t pt_x, pt_y;
    logic             pt_in;
    logic [RW-1:0]    pt_row;
    always_comb
    begin
        unique case (k_reg)
            2'd0: pt_x = xa_reg;
            2'd1: pt_x = xb_reg;
            2'd2: pt_x = tailpts_reg ? xa_reg : xb_reg;
            default: pt_x = tailpts_reg ? xb_reg : xa_reg;
        endcase
        pt_y   = k_reg[1] ? pl_reg : pu_reg;
        pt_in  = !pt_y[eirr_pkg::CRD_W-1] && (pt_y < eirr_pkg::coord_t'(eirr_pkg::ROWS));
        pt_row = pt_y[RW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eirr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == eirr_pkg::OP_START)
                        state_next = eirr_pkg::ST_MUL_AA;
                    else
                    begin
                        unique case (phase_reg)
                            eirr_pkg::PH_WALK: state_next = eirr_pkg::ST_STEP_Y;
                            eirr_pkg::PH_TAIL: state_next = eirr_pkg::ST_TAIL;
                            eirr_pkg::PH_SCAN: state_next = eirr_pkg::ST_SCAN_RD;
                            default:           state_next = eirr_pkg::ST_EMIT;
                        endcase
                    end
                end
            end
            eirr_pkg::ST_MUL_AA:  state_next = eirr_pkg::ST_MUL_BB;
            eirr_pkg::ST_MUL_BB:  state_next = eirr_pkg::ST_MUL_DX;
            eirr_pkg::ST_MUL_DX:  state_next = eirr_pkg::ST_INIT;
            eirr_pkg::ST_INIT:    state_next = eirr_pkg::ST_EMIT;
            eirr_pkg::ST_STEP_Y:  state_next = eirr_pkg::ST_STEP_Y2;
            eirr_pkg::ST_STEP_Y2: state_next = eirr_pkg::ST_STEP_X;
            eirr_pkg::ST_STEP_X:  state_next = eirr_pkg::ST_STEP_X2;
            eirr_pkg::ST_STEP_X2: state_next = eirr_pkg::ST_PLOT;
            eirr_pkg::ST_TAIL:    state_next = eirr_pkg::ST_PLOT;
            eirr_pkg::ST_PLOT:
            begin
                if (!fill_reg)
                begin
                    if (out_free)
                        state_next = (k_reg == 2'd3) ? eirr_pkg::ST_IDLE : eirr_pkg::ST_PLOT;
                end
                else if (pt_in && seen_reg[pt_row])
                    state_next = eirr_pkg::ST_UPD;
                else
                    state_next = (k_reg == 2'd3) ? eirr_pkg::ST_FEND : eirr_pkg::ST_PLOT;
            end
            eirr_pkg::ST_UPD:
                state_next = (k_reg == 2'd3) ? eirr_pkg::ST_FEND : eirr_pkg::ST_PLOT;
            eirr_pkg::ST_FEND:
                state_next = fin_reg ? eirr_pkg::ST_SEEK : eirr_pkg::ST_EMIT;
            eirr_pkg::ST_SEEK:
            begin
                if (sr_reg[RW])
                    state_next = eirr_pkg::ST_EMIT;
                else if (seen_reg[sr_reg[RW-1:0]])
                    state_next = eirr_pkg::ST_LOAD;
            end
            eirr_pkg::ST_LOAD:    state_next = eirr_pkg::ST_EMIT;
            eirr_pkg::ST_SCAN_RD: state_next = eirr_pkg::ST_SCAN_CMP;
            eirr_pkg::ST_SCAN_CMP:
            begin
                if (scan_x_reg < ram_rdata[15:8])
                begin
                    if (out_free)
                        state_next = eirr_pkg::ST_IDLE;
                end
                else
                    state_next = eirr_pkg::ST_SEEK;
            end
            eirr_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = eirr_pkg::ST_IDLE;
            end
            default: state_next = eirr_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    logic [7:0]       st_a, st_b, st_xmin, st_ymin;
    eirr_pkg::coord_t st_up;
    eirr_pkg::err_t   dy_init, e2_now;
    logic             emit;
    eirr_pkg::result_t emit_res;

    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        upper_next      = upper_reg;
        lower_next      = lower_reg;
        xa_next         = xa_reg;
        xb_next         = xb_reg;
        pu_next         = pu_reg;
        pl_next         = pl_reg;
        hspan_next      = hspan_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        aa_next         = aa_reg;
        bb_next         = bb_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        err_next        = err_reg;
        e2_next         = e2_reg;
        xi_next         = xi_reg;
        yi_next         = yi_reg;
        fill_next       = fill_reg;
        cy_next         = cy_reg;
        cx_next         = cx_reg;
        fin_next        = fin_reg;
        tailn_next      = tailn_reg;
        tailpts_next    = tailpts_reg;
        k_next          = k_reg;
        seen_next       = seen_reg;
        sr_next         = sr_reg;
        scan_row_next   = scan_row_reg;
        scan_x_next     = scan_x_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_valid_next = pend_valid_reg;
        pend_done_next  = pend_done_reg;
        mul_a           = '0;
        mul_b           = '0;
        ram_we          = 1'b0;
        ram_addr        = pt_row;
        ram_wdata       = {pt_x[7:0], pt_x[7:0]};
        emit            = 1'b0;
        emit_res        = '0;

        st_a    = (in_ax > in_bx) ? in_ax - in_bx : in_bx - in_ax;
        st_b    = (in_ay > in_by) ? in_ay - in_by : in_by - in_ay;
        st_xmin = (in_ax < in_bx) ? in_ax : in_bx;
        st_ymin = (in_ay < in_by) ? in_ay : in_by;
        st_up   = eirr_pkg::coord_t'(st_ymin)
                + eirr_pkg::coord_t'(({1'b0, st_b} + 9'd1) >> 1);
        dy_init = b_reg[0] ? (eirr_pkg::err_t'(aa_reg) <<< 3)
                           : (eirr_pkg::err_t'(aa_reg) <<< 2);
        e2_now  = err_reg <<< 1;

        unique case (state_reg)
            eirr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == eirr_pkg::OP_START)
                    begin
                        // box setup; error terms follow on the multiplier
                        a_next        = st_a;
                        b_next        = st_b;
                        left_next     = eirr_pkg::coord_t'(st_xmin);
                        right_next    = eirr_pkg::coord_t'(st_xmin) + eirr_pkg::coord_t'(st_a);
                        upper_next    = st_up;
                        lower_next    = st_up - eirr_pkg::coord_t'(st_b[0]);
                        hspan_next    = st_b;
                        fill_next     = in_fill;
                        seen_next     = '0;
                        scan_row_next = '0;
                        scan_x_next   = '0;
                        phase_next    = eirr_pkg::PH_WALK;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        pend_x_next     = '0;
                        pend_y_next     = '0;
                        pend_done_next  = (phase_reg == eirr_pkg::PH_DONE);
                    end
                end
            end
            eirr_pkg::ST_MUL_AA:
            begin
                mul_a   = eirr_pkg::MUL_W'(a_reg);
                mul_b   = eirr_pkg::MUL_W'(a_reg);
                aa_next = mul_p[eirr_pkg::SQ_W-1:0];
                yi_next = eirr_pkg::INC_W'({mul_p[eirr_pkg::SQ_W-1:0], 3'b000});
            end
            eirr_pkg::ST_MUL_BB:
            begin
                mul_a    = eirr_pkg::MUL_W'(b_reg);
                mul_b    = eirr_pkg::MUL_W'(b_reg);
                bb_next  = mul_p[eirr_pkg::SQ_W-1:0];
                xi_next  = eirr_pkg::INC_W'({mul_p[eirr_pkg::SQ_W-1:0], 3'b000});
                dy_next  = dy_init;
                // partial error: dy plus a*a for odd heights
                err_next = dy_init + (b_reg[0] ? eirr_pkg::err_t'(aa_reg) : '0);
            end
            eirr_pkg::ST_MUL_DX:
            begin
                mul_a   = eirr_pkg::MUL_W'(1) - eirr_pkg::MUL_W'(a_reg);
                mul_b   = eirr_pkg::MUL_W'(bb_reg);
                dx_next = eirr_pkg::err_t'(mul_p) <<< 2;
            end
            eirr_pkg::ST_INIT:
            begin
                err_next        = dx_reg + err_reg;
                pend_valid_next = 1'b0;
                pend_x_next     = '0;
                pend_y_next     = '0;
                pend_done_next  = 1'b0;
            end
            eirr_pkg::ST_STEP_Y:
            begin
                xa_next      = right_reg;
                xb_next      = left_reg;
                pu_next      = upper_reg;
                pl_next      = lower_reg;
                tailpts_next = 1'b0;
                k_next       = '0;
                e2_next      = e2_now;
                cy_next      = (e2_now <= dy_reg);
                if (e2_now <= dy_reg)
                begin
                    upper_next = upper_reg + eirr_pkg::coord_t'(1);
                    lower_next = lower_reg - eirr_pkg::coord_t'(1);
                    dy_next    = dy_reg + eirr_pkg::err_t'(yi_reg);
                end
            end
            eirr_pkg::ST_STEP_Y2:
            begin
                if (cy_reg)
                    err_next = err_reg + dy_reg;
            end
            eirr_pkg::ST_STEP_X:
            begin
                cx_next = (e2_reg >= dx_reg) || (e2_now > dy_reg);
                if ((e2_reg >= dx_reg) || (e2_now > dy_reg))
                begin
                    left_next  = left_reg + eirr_pkg::coord_t'(1);
                    right_next = right_reg - eirr_pkg::coord_t'(1);
                    dx_next    = dx_reg + eirr_pkg::err_t'(xi_reg);
                end
            end
            eirr_pkg::ST_STEP_X2:
            begin
                if (cx_reg)
                    err_next = err_reg + dx_reg;
                // walk over: flat-end tail if rows are still missing
                fin_next   = (left_reg > right_reg)
                          && !((upper_reg - lower_reg) <= eirr_pkg::coord_t'(hspan_reg));
                tailn_next = (left_reg > right_reg)
                          && ((upper_reg - lower_reg) <= eirr_pkg::coord_t'(hspan_reg));
            end
            eirr_pkg::ST_TAIL:
            begin
                xa_next      = left_reg - eirr_pkg::coord_t'(1);
                xb_next      = right_reg + eirr_pkg::coord_t'(1);
                pu_next      = upper_reg;
                pl_next      = lower_reg;
                tailpts_next = 1'b1;
                k_next       = '0;
                upper_next   = upper_reg + eirr_pkg::coord_t'(1);
                lower_next   = lower_reg - eirr_pkg::coord_t'(1);
                fin_next     = (upper_reg - lower_reg + eirr_pkg::coord_t'(2))
                             > eirr_pkg::coord_t'(hspan_reg);
                tailn_next   = 1'b0;
            end
            eirr_pkg::ST_PLOT:
            begin
                if (!fill_reg)
                begin
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        emit_res.x     = pt_x[7:0];
                        emit_res.y     = pt_y[7:0];
                        emit_res.valid = 1'b1;
                        emit_res.last  = (k_reg == 2'd3);
                        emit_res.done  = (k_reg == 2'd3) && fin_reg;
                        k_next         = k_reg + 2'd1;
                        if (k_reg == 2'd3)
                        begin
                            if (fin_reg)
                                phase_next = eirr_pkg::PH_DONE;
                            else if (tailn_reg)
                                phase_next = eirr_pkg::PH_TAIL;
                        end
                    end
                end
                else if (pt_in && seen_reg[pt_row])
                begin
                    // read now, merge next cycle
                    ram_addr = pt_row;
                end
                else
                begin
                    if (pt_in)
                    begin
                        ram_we            = 1'b1;
                        ram_wdata         = {pt_x[7:0], pt_x[7:0]};
                        seen_next[pt_row] = 1'b1;
                    end
                    k_next = k_reg + 2'd1;
                end
            end
            eirr_pkg::ST_UPD:
            begin
                ram_we    = 1'b1;
                ram_addr  = pt_row;
                ram_wdata = {(pt_x[7:0] > ram_rdata[15:8]) ? pt_x[7:0] : ram_rdata[15:8],
                             (pt_x[7:0] < ram_rdata[7:0])  ? pt_x[7:0] : ram_rdata[7:0]};
                k_next    = k_reg + 2'd1;
            end
            eirr_pkg::ST_FEND:
            begin
                pend_valid_next = 1'b0;
                pend_x_next     = '0;
                pend_y_next     = '0;
                pend_done_next  = 1'b0;
                if (fin_reg)
                    sr_next = '0;
                else if (tailn_reg)
                    phase_next = eirr_pkg::PH_TAIL;
            end
            eirr_pkg::ST_SEEK:
            begin
                ram_addr = sr_reg[RW-1:0];
                if (sr_reg[RW])
                begin
                    phase_next     = eirr_pkg::PH_DONE;
                    pend_done_next = 1'b1;
                end
                else if (!seen_reg[sr_reg[RW-1:0]])
                    sr_next = sr_reg + 1'b1;
            end
            eirr_pkg::ST_LOAD:
            begin
                scan_row_next  = sr_reg[RW-1:0];
                scan_x_next    = ram_rdata[7:0];
                phase_next     = eirr_pkg::PH_SCAN;
                pend_done_next = 1'b0;
            end
            eirr_pkg::ST_SCAN_RD:
            begin
                ram_addr = scan_row_reg;
            end
            eirr_pkg::ST_SCAN_CMP:
            begin
                // keep the row entry on the read port while the output stalls
                ram_addr = scan_row_reg;
                if (scan_x_reg < ram_rdata[15:8])
                begin
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        emit_res.x     = scan_x_reg;
                        emit_res.y     = scan_row_reg;
                        emit_res.valid = 1'b1;
                        emit_res.last  = 1'b1;
                        emit_res.done  = 1'b0;
                        scan_x_next    = scan_x_reg + 8'd1;
                    end
                end
                else
                begin
                    // row finished: hold the pixel until the next row is found
                    pend_valid_next = 1'b1;
                    pend_x_next     = scan_x_reg;
                    pend_y_next     = scan_row_reg;
                    pend_done_next  = 1'b0;
                    sr_next         = {1'b0, scan_row_reg} + 1'b1;
                end
            end
            eirr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_res.x     = pend_x_reg;
                    emit_res.y     = pend_y_reg;
                    emit_res.valid = pend_valid_reg;
                    emit_res.last  = 1'b1;
                    emit_res.done  = pend_done_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // output register: a result waits here while the sequencer moves on
        out_next       = emit ? emit_res : out_reg;
        out_valid_next = emit ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= eirr_pkg::ST_IDLE;
            phase_reg      <= eirr_pkg::PH_IDLE;
            left_reg       <= '0;
            right_reg      <= '0;
            upper_reg      <= '0;
            lower_reg      <= '0;
            hspan_reg      <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            err_reg        <= '0;
            xi_reg         <= '0;
            yi_reg         <= '0;
            fill_reg       <= 1'b0;
            seen_reg       <= '0;
            scan_row_reg   <= '0;
            scan_x_reg     <= '0;
            k_reg          <= '0;
            sr_reg         <= '0;
            fin_reg        <= 1'b0;
            tailn_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            upper_reg      <= upper_next;
            lower_reg      <= lower_next;
            hspan_reg      <= hspan_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            err_reg        <= err_next;
            xi_reg         <= xi_next;
            yi_reg         <= yi_next;
            fill_reg       <= fill_next;
            seen_reg       <= seen_next;
            scan_row_reg   <= scan_row_next;
            scan_x_reg     <= scan_x_next;
            k_reg          <= k_next;
            sr_reg         <= sr_next;
            fin_reg        <= fin_next;
            tailn_reg      <= tailn_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        xa_reg         <= xa_next;
        xb_reg         <= xb_next;
        pu_reg         <= pu_next;
        pl_reg         <= pl_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        aa_reg         <= aa_next;
        bb_reg         <= bb_next;
        e2_reg         <= e2_next;
        cy_reg         <= cy_next;
        cx_reg         <= cx_next;
        tailpts_reg    <= tailpts_next;
        pend_x_reg     <= pend_x_next;
        pend_y_reg     <= pend_y_next;
        pend_valid_reg <= pend_valid_next;
        pend_done_reg  <= pend_done_next;
        out_reg        <= out_next;
    end

    `EIRR_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "taken while busy")
    `EIRR_ASSERT_IMP(a_ack_is_last, m_tvalid && !m_tuser, m_tlast, "ack not final")
    `EIRR_ASSERT_IMP(a_done_on_last, m_tvalid && out_reg.done, m_tlast, "done before last")
    `EIRR_ASSERT_IMP(a_scan_row_seen, phase_reg == eirr_pkg::PH_SCAN, seen_reg[scan_row_reg], "bad row")

endmodule
